// ===== rtl/lrust_pkg.sv =====
// Package for the LRU recency stack tracker.
// Holds the sizes, command codes, word structs and sequencer types.
// No dependencies; every rtl file refers to it by scoped names.
package lrust_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int KEY_W = 8;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_DUMP = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] entry;
		logic entry_valid;
		logic last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DUMP,
		ST_EMPTY
	} state_t;

	// Controls from the sequencer to the key store.
	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic wr_key;
		logic key_load;
	} ctl_t;

endpackage

// ===== rtl/lrust_store.sv =====
// Key store of the LRU recency stack tracker: the stack memory and the
// shared key comparator. Depends on lrust_pkg.
module lrust_store (
	input  logic                        clk,
	input  lrust_pkg::ctl_t             ctl,
	input  logic [lrust_pkg::KEY_W-1:0] key,
	output logic [lrust_pkg::KEY_W-1:0] rd_data,
	output logic                        match
);

	logic [lrust_pkg::KEY_W-1:0] mem [lrust_pkg::STACK_DEPTH];
	logic [lrust_pkg::KEY_W-1:0] rd_data_q;
	logic [lrust_pkg::KEY_W-1:0] key_q;
	logic [lrust_pkg::KEY_W-1:0] wr_data;

	// Shifting passes write back the word just read; the final write stores the key.
	assign wr_data = ctl.wr_key ? key_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.key_load) begin
			key_q <= key;
		end
	end

	assign rd_data = rd_data_q;
	assign match = (rd_data_q == key_q);

endmodule

// ===== rtl/lrust_ctrl.sv =====
// Sequencer of the LRU recency stack tracker: command decode, search and
// shift passes, dump output and the capacity register. Depends on lrust_pkg.
module lrust_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  cmd,
	output logic                        busy,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lrust_pkg::CFG_W-1:0] cfg_data,
	output lrust_pkg::ctl_t             ctl,
	input  logic [lrust_pkg::KEY_W-1:0] rd_data,
	input  logic                        match,
	output logic                        result_strobe,
	output lrust_pkg::rsp_t             result
);

	localparam int IW = lrust_pkg::IDX_W;
	localparam int CW = lrust_pkg::CNT_W;

	lrust_pkg::state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [IW-1:0] pidx_q, pidx_d;
	logic pv_q, pv_d;
	logic hit_q, hit_d;
	logic grow_q, grow_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [lrust_pkg::CFG_W-1:0] cap_q;
	logic [CW-1:0] eff_cap;
	logic [CW-1:0] occ_m1;
	logic last_elem;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > lrust_pkg::STACK_DEPTH) begin
			eff_cap = CW'(lrust_pkg::STACK_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign occ_m1 = occ_q - CW'(1);
	// The word in the read register is the most recent stored key.
	assign last_elem = pv_q && (CW'(pidx_q) == occ_m1);

	assign busy = (state_q != lrust_pkg::ST_IDLE);
	assign cfg_ready = (state_q == lrust_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrust_pkg::ST_IDLE;
			idx_q <= '0;
			pidx_q <= '0;
			pv_q <= 1'b0;
			hit_q <= 1'b0;
			grow_q <= 1'b0;
			occ_q <= '0;
			cap_q <= lrust_pkg::CAP_RESET;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pidx_q <= pidx_d;
			pv_q <= pv_d;
			hit_q <= hit_d;
			grow_q <= grow_d;
			occ_q <= occ_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pidx_d = pidx_q;
		pv_d = 1'b0;
		hit_d = hit_q;
		grow_d = grow_q;
		occ_d = occ_q;
		ctl = '0;
		result_strobe = 1'b0;
		result = '0;

		unique case (state_q)
			lrust_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd)
						lrust_pkg::CMD_ACCESS: begin
							ctl.key_load = 1'b1;
							idx_d = '0;
							hit_d = 1'b0;
							if (occ_q == '0) begin
								grow_d = 1'b1;
								state_d = lrust_pkg::ST_TAIL;
							end else begin
								state_d = lrust_pkg::ST_SCAN;
							end
						end
						lrust_pkg::CMD_DUMP: begin
							idx_d = '0;
							if (occ_q == '0) begin
								state_d = lrust_pkg::ST_EMPTY;
							end else begin
								state_d = lrust_pkg::ST_DUMP;
							end
						end
						lrust_pkg::CMD_CLEAR: begin
							occ_d = '0;
						end
						default: begin
						end
					endcase
				end
			end

			lrust_pkg::ST_SCAN: begin
				if (idx_q < occ_q) begin
					ctl.rd_en = 1'b1;
					ctl.rd_addr = idx_q[IW-1:0];
					idx_d = idx_q + CW'(1);
					pv_d = 1'b1;
					pidx_d = idx_q[IW-1:0];
				end
				if (pv_q) begin
					// Once the key is found, every later word moves one slot down.
					if (hit_q) begin
						ctl.wr_en = 1'b1;
						ctl.wr_addr = pidx_q - IW'(1);
					end else if (match) begin
						hit_d = 1'b1;
					end
				end
				if (last_elem) begin
					if (hit_q || match) begin
						grow_d = 1'b0;
						state_d = lrust_pkg::ST_TAIL;
					end else if (occ_q >= eff_cap) begin
						grow_d = 1'b0;
						if (occ_q == CW'(1)) begin
							state_d = lrust_pkg::ST_TAIL;
						end else begin
							// Evict the least recent key: a second pass from slot 1
							// that shifts everything down.
							idx_d = CW'(1);
							hit_d = 1'b1;
						end
					end else begin
						grow_d = 1'b1;
						state_d = lrust_pkg::ST_TAIL;
					end
				end
			end

			lrust_pkg::ST_TAIL: begin
				ctl.wr_en = 1'b1;
				ctl.wr_key = 1'b1;
				if (grow_q) begin
					ctl.wr_addr = occ_q[IW-1:0];
					occ_d = occ_q + CW'(1);
				end else begin
					ctl.wr_addr = occ_m1[IW-1:0];
				end
				state_d = lrust_pkg::ST_IDLE;
			end

			lrust_pkg::ST_DUMP: begin
				if (idx_q < occ_q) begin
					ctl.rd_en = 1'b1;
					ctl.rd_addr = idx_q[IW-1:0];
					idx_d = idx_q + CW'(1);
					pv_d = 1'b1;
					pidx_d = idx_q[IW-1:0];
				end
				if (pv_q) begin
					result_strobe = 1'b1;
					result.entry = rd_data;
					result.entry_valid = 1'b1;
					result.last = last_elem;
				end
				if (last_elem) begin
					state_d = lrust_pkg::ST_IDLE;
				end
			end

			lrust_pkg::ST_EMPTY: begin
				result_strobe = 1'b1;
				result.last = 1'b1;
				state_d = lrust_pkg::ST_IDLE;
			end
		endcase
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= lrust_pkg::STACK_DEPTH)
		else $error("occupancy exceeds the stack depth");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (state_q == lrust_pkg::ST_DUMP || state_q == lrust_pkg::ST_EMPTY))
		else $error("result word outside a dump");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && ctl.rd_en) |-> (ctl.wr_addr != ctl.rd_addr))
		else $error("read and write to the same slot in one cycle");

	a_tail_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrust_pkg::ST_TAIL) |=> (state_q == lrust_pkg::ST_IDLE))
		else $error("insert step did not finish the access");

	a_grow_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrust_pkg::ST_TAIL && grow_q) |-> (occ_q < eff_cap))
		else $error("insert without eviction on a full stack");

endmodule

// ===== rtl/lru_stack_tracker_core.sv =====
// Top level of the LRU recency stack tracker.
// Instantiates lrust_ctrl and lrust_store; depends on lrust_pkg.
//
// A command word is taken when start is high and busy is low; for an access
// or a dump, busy then stays high until the command is done. A clear, or the
// unused command code, is done in the accept cycle and leaves busy low. An
// access to an empty stack goes straight to the write of the key; otherwise it
// reads every stored key through the shared key comparator, compares the most
// recent word, and then writes the key itself. A miss on a full stack that
// holds more than one key adds a second shifting pass to evict the least
// recent key. A dump puts one result word per stored key on result in
// consecutive cycles, least recent first, the first one once slot 0 has been
// read into the read register, each marked by result_strobe for one cycle;
// there is no backpressure, so the receiver must take every word as it comes.
// A dump of an empty stack gives one word with entry_valid low in the cycle
// after the accept. The capacity register is written through
// cfg_valid/cfg_ready while busy is low; clear the stack after changing it.
module lru_stack_tracker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lrust_pkg::req_t             request,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lrust_pkg::CFG_W-1:0] cfg_data,
	output logic                        result_strobe,
	output lrust_pkg::rsp_t             result
);

	lrust_pkg::ctl_t ctl;
	logic [lrust_pkg::KEY_W-1:0] rd_data;
	logic match;

	lrust_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (request.cmd),
		.busy          (busy),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.ctl           (ctl),
		.rd_data       (rd_data),
		.match         (match),
		.result_strobe (result_strobe),
		.result        (result)
	);

	lrust_store u_store (
		.clk     (clk),
		.ctl     (ctl),
		.key     (request.key),
		.rd_data (rd_data),
		.match   (match)
	);

endmodule
